### sv/sample_hold_downsampler_macros.svh
// ----------------------------------------------------------------------------
// Sample-and-hold downsampler assertion macros
// Shared concurrent assertion forms for the checker, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_HOLD_DOWNSAMPLER_MACROS_SVH
`define SAMPLE_HOLD_DOWNSAMPLER_MACROS_SVH

// Assertion that is ignored while reset is high.
`define SHD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked across the reset cycle.
`define SHD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/shd_pkg.sv
// ----------------------------------------------------------------------------
// Sample-and-hold downsampler package
// Widths, constants, shared types and saturation helpers.
// ----------------------------------------------------------------------------
package shd_pkg;

  // Sample and item field widths.
  localparam int SAMPLE_WIDTH = 24;
  localparam int FREQ_WIDTH   = 32;
  localparam int RECIP_WIDTH  = 40;
  localparam int RECIP_SPLIT  = 20;

  // Phase accumulator, signed Q3.29.
  localparam int PHASE_WIDTH = 32;
  localparam int FRAC        = 29;
  localparam logic signed [PHASE_WIDTH-1:0] PHASE_ONE = 32'sh2000_0000;
  localparam logic signed [PHASE_WIDTH-1:0] PHASE_MAX = 32'sh7fff_ffff;
  localparam logic signed [PHASE_WIDTH-1:0] PHASE_MIN = 32'sh8000_0000;

  // Step magnitude: product of freq (Q20.12) and recip_rate (2^-50) moved to Q29.
  localparam int STEP_SHIFT     = 33;
  localparam int STEP_MAG_WIDTH = FRAC + 1;
  localparam logic [STEP_MAG_WIDTH-1:0] STEP_ONE = 30'h2000_0000;

  // Interpolation product split.
  localparam int DIFF_WIDTH = SAMPLE_WIDTH + 1;
  localparam int MAG_WIDTH  = PHASE_WIDTH;
  localparam int M_SPLIT    = 16;

  // Queues between front and back, and at the output.
  localparam int MID_DEPTH = 4;
  localparam int MID_AW    = $clog2(MID_DEPTH);
  localparam int MID_CW    = $clog2(MID_DEPTH + 1) + 1;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  // Configuration port.
  localparam int ADDR_WIDTH  = 4;
  localparam int DATA_WIDTH  = 64;
  localparam int REG_SEL_BIT = 3;
  localparam logic [RECIP_WIDTH-1:0] RECIP_RESET = 40'd25530610133;

  typedef enum logic {
    REG_RECIP_RATE  = 1'b0,
    REG_INTERPOLATE = 1'b1
  } shd_reg_t;

  typedef logic [MID_CW-1:0] mid_cnt_t;
  typedef logic [OUT_CW-1:0] out_cnt_t;

  // Item passed from the front to the back through the middle queue.
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           neg;
    logic [STEP_MAG_WIDTH-1:0]      step_mag;
  } shd_mid_t;

  // Middle queue status seen by both sides.
  typedef struct packed {
    logic     empty;
    mid_cnt_t count;
  } shd_qstat_t;

  // Clamp a one-bit-wider phase value to the 32-bit signed range.
  function automatic logic signed [PHASE_WIDTH-1:0] sat_phase(
    input logic signed [PHASE_WIDTH:0] v
  );
    logic signed [PHASE_WIDTH-1:0] r;
    if (v[PHASE_WIDTH] != v[PHASE_WIDTH-1]) begin
      r = v[PHASE_WIDTH] ? PHASE_MIN : PHASE_MAX;
    end else begin
      r = v[PHASE_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

### sv/shd_queue.sv
// ----------------------------------------------------------------------------
// Middle item queue
// Short first-in first-out store between the step front end and the back end.
// ----------------------------------------------------------------------------
module shd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  shd_pkg::shd_mid_t    wr_item,
  input  logic                 rd_en,
  output shd_pkg::shd_mid_t    rd_item,
  output shd_pkg::shd_qstat_t  qstat
);

  shd_pkg::shd_mid_t            mem [shd_pkg::MID_DEPTH];
  logic [shd_pkg::MID_AW-1:0]   wr_ptr;
  logic [shd_pkg::MID_AW-1:0]   rd_ptr;
  shd_pkg::mid_cnt_t            count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + shd_pkg::mid_cnt_t'(wr_en) - shd_pkg::mid_cnt_t'(rd_en);
    end
  end

  assign rd_item     = mem[rd_ptr];
  assign qstat.empty = (count == '0);
  assign qstat.count = count;

endmodule

### sv/shd_front.sv
// ----------------------------------------------------------------------------
// Step front end
// Accepts items and works out the clipped step magnitude in two stages.
// ----------------------------------------------------------------------------
module shd_front (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     accept,
  input  logic signed [shd_pkg::SAMPLE_WIDTH-1:0]  sample,
  input  logic signed [shd_pkg::FREQ_WIDTH-1:0]    freq,
  input  logic [shd_pkg::RECIP_WIDTH-1:0]          recip_rate,
  input  shd_pkg::shd_qstat_t                      qstat,
  output logic                                     full,
  output logic                                     wr_en,
  output shd_pkg::shd_mid_t                        wr_item
);

  localparam int PartW = shd_pkg::FREQ_WIDTH + shd_pkg::RECIP_SPLIT;
  localparam int SumW  = shd_pkg::FREQ_WIDTH + shd_pkg::RECIP_WIDTH;

  typedef logic [PartW-1:0] part_t;
  typedef logic [SumW-1:0]  sum_t;

  logic [shd_pkg::FREQ_WIDTH-1:0]         mag;
  part_t                                  prod_hi;
  part_t                                  prod_lo;
  shd_pkg::mid_cnt_t                      fill;

  logic                                   v1;
  logic signed [shd_pkg::SAMPLE_WIDTH-1:0] s1_sample;
  logic                                   s1_neg;
  part_t                                  s1_hi;
  part_t                                  s1_lo;

  sum_t                                   acc;
  sum_t                                   shifted;
  logic [shd_pkg::STEP_MAG_WIDTH-1:0]     step_mag;

  logic                                   v2;
  shd_pkg::shd_mid_t                      s2_item;

  // Stage 1: magnitude of freq times both halves of recip_rate.
  always_comb begin
    mag = freq[shd_pkg::FREQ_WIDTH-1] ? (~$unsigned(freq) + 1'b1) : $unsigned(freq);
    prod_hi = part_t'(mag)
            * part_t'(recip_rate[shd_pkg::RECIP_WIDTH-1:shd_pkg::RECIP_SPLIT]);
    prod_lo = part_t'(mag) * part_t'(recip_rate[shd_pkg::RECIP_SPLIT-1:0]);
  end

  // Stage 2: join the partial products, scale to Q29 and clip at 1.0.
  always_comb begin
    acc     = (sum_t'(s1_hi) << shd_pkg::RECIP_SPLIT) + sum_t'(s1_lo);
    shifted = acc >> shd_pkg::STEP_SHIFT;
    if (shifted > sum_t'(shd_pkg::STEP_ONE)) begin
      step_mag = shd_pkg::STEP_ONE;
    end else begin
      step_mag = shifted[shd_pkg::STEP_MAG_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s1_sample <= sample;
    s1_neg    <= freq[shd_pkg::FREQ_WIDTH-1];
    s1_hi     <= prod_hi;
    s1_lo     <= prod_lo;
    s2_item.sample   <= s1_sample;
    s2_item.neg      <= s1_neg;
    s2_item.step_mag <= step_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  // Every item in flight here already owns a slot in the middle queue.
  assign fill    = qstat.count + shd_pkg::mid_cnt_t'(v1) + shd_pkg::mid_cnt_t'(v2);
  assign full    = (fill >= shd_pkg::mid_cnt_t'(shd_pkg::MID_DEPTH));
  assign wr_en   = v2;
  assign wr_item = s2_item;

endmodule

### sv/shd_back.sv
// ----------------------------------------------------------------------------
// Hold back end
// Phase update, sample capture, interpolation pipeline and result queue.
// ----------------------------------------------------------------------------
module shd_back (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     interpolate,
  input  shd_pkg::shd_qstat_t                      qstat,
  input  shd_pkg::shd_mid_t                        rd_item,
  output logic                                     rd_en,
  input  logic                                     pop,
  output logic                                     empty,
  output logic signed [shd_pkg::SAMPLE_WIDTH-1:0]  out_sample
);

  localparam int SW    = shd_pkg::SAMPLE_WIDTH;
  localparam int PW    = shd_pkg::PHASE_WIDTH;
  localparam int ProdW = shd_pkg::DIFF_WIDTH + shd_pkg::M_SPLIT;
  localparam int WideW = shd_pkg::DIFF_WIDTH + shd_pkg::MAG_WIDTH;
  localparam int QW    = WideW - shd_pkg::FRAC;
  localparam int YW    = QW + 2;

  typedef logic signed [PW:0]    ph_wide_t;
  typedef logic signed [SW:0]    diff_t;
  typedef logic [ProdW-1:0]      prod_t;
  typedef logic [WideW-1:0]      wide_t;
  typedef logic [QW-1:0]         q_t;
  typedef logic signed [YW-1:0]  y_t;

  localparam y_t SMAX_Y = {{(YW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam y_t SMIN_Y = ~SMAX_Y;

  // Architectural state.
  logic signed [PW-1:0]  phase;
  logic signed [SW-1:0]  held_sample;
  logic signed [SW-1:0]  older_sample;

  // State update terms.
  logic                  trig;
  ph_wide_t              ph_w;
  ph_wide_t              one_w;
  ph_wide_t              moved_sum;
  logic signed [PW-1:0]  moved;
  ph_wide_t              moved_w;
  ph_wide_t              step_w;
  ph_wide_t              adv;
  logic signed [PW-1:0]  phase_next;
  logic signed [SW-1:0]  held_next;
  logic signed [SW-1:0]  older_next;
  diff_t                 diff;
  diff_t                 diff_neg;
  ph_wide_t              m_w;
  ph_wide_t              m_neg;
  logic [SW:0]           dmag;
  logic [PW-1:0]         mmag;

  // Interpolation pipeline.
  logic                  vb1;
  logic                  vb2;
  logic                  vb3;
  logic [SW:0]           b1_dmag;
  logic [PW-1:0]         b1_mmag;
  logic                  b1_pneg;
  logic                  b1_interp;
  logic signed [SW-1:0]  b1_held;
  logic signed [SW-1:0]  b1_older;
  prod_t                 b2_hi;
  prod_t                 b2_lo;
  logic                  b2_pneg;
  logic                  b2_interp;
  logic signed [SW-1:0]  b2_held;
  logic signed [SW-1:0]  b2_older;
  q_t                    b3_q;
  logic                  b3_pneg;
  logic                  b3_interp;
  logic signed [SW-1:0]  b3_held;
  logic signed [SW-1:0]  b3_older;
  wide_t                 wide_sum;
  y_t                    q_ext;
  y_t                    y_sum;
  logic signed [SW-1:0]  y_sat;
  logic signed [SW-1:0]  y_out;

  // Result queue.
  logic signed [SW-1:0]         omem [shd_pkg::OUT_DEPTH];
  logic [shd_pkg::OUT_AW-1:0]   owr_ptr;
  logic [shd_pkg::OUT_AW-1:0]   ord_ptr;
  shd_pkg::out_cnt_t            ocount;
  shd_pkg::out_cnt_t            ofill;
  logic                         opop;

  // Take an item only when the result queue has room for it and all
  // items still in the interpolation pipeline.
  assign ofill = ocount + shd_pkg::out_cnt_t'(vb1) + shd_pkg::out_cnt_t'(vb2)
               + shd_pkg::out_cnt_t'(vb3);
  assign rd_en = !qstat.empty && (ofill < shd_pkg::out_cnt_t'(shd_pkg::OUT_DEPTH));

  // Trigger test on the old phase, phase move, then the step.
  always_comb begin
    trig      = (phase >= shd_pkg::PHASE_ONE) || phase[PW-1] || (phase == '0);
    ph_w      = {phase[PW-1], phase};
    one_w     = {1'b0, shd_pkg::PHASE_ONE};
    moved_sum = rd_item.neg ? (ph_w + one_w) : (ph_w - one_w);
    moved     = trig ? shd_pkg::sat_phase(moved_sum) : phase;
    moved_w   = {moved[PW-1], moved};
    step_w    = {{(PW+1-shd_pkg::STEP_MAG_WIDTH){1'b0}}, rd_item.step_mag};
    adv       = rd_item.neg ? (moved_w - step_w) : (moved_w + step_w);
    phase_next = shd_pkg::sat_phase(adv);

    held_next  = trig ? rd_item.sample : held_sample;
    older_next = trig ? held_sample : older_sample;

    diff     = {held_next[SW-1], held_next} - {older_next[SW-1], older_next};
    diff_neg = -diff;
    dmag     = diff[SW] ? diff_neg : diff;
    m_w      = one_w - moved_w;
    m_neg    = -m_w;
    mmag     = m_w[PW] ? m_neg[PW-1:0] : m_w[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= shd_pkg::PHASE_ONE;
      held_sample  <= '0;
      older_sample <= '0;
    end else if (rd_en) begin
      phase        <= phase_next;
      held_sample  <= held_next;
      older_sample <= older_next;
    end
  end

  // Result sum: older plus the signed, truncated product term.
  always_comb begin
    wide_sum = (wide_t'(b2_hi) << shd_pkg::M_SPLIT) + wide_t'(b2_lo);
    q_ext    = {2'b00, b3_q};
    y_sum    = {{(YW-SW){b3_older[SW-1]}}, b3_older} + (b3_pneg ? -q_ext : q_ext);
    if (y_sum > SMAX_Y) begin
      y_sat = SMAX_Y[SW-1:0];
    end else if (y_sum < SMIN_Y) begin
      y_sat = SMIN_Y[SW-1:0];
    end else begin
      y_sat = y_sum[SW-1:0];
    end
    y_out = b3_interp ? y_sat : b3_held;
  end

  always_ff @(posedge clk) begin
    b1_dmag   <= dmag;
    b1_mmag   <= mmag;
    b1_pneg   <= diff[SW] ^ m_w[PW];
    b1_interp <= rd_item.neg && interpolate;
    b1_held   <= held_next;
    b1_older  <= older_next;

    b2_hi     <= prod_t'(b1_dmag) * prod_t'(b1_mmag[PW-1:shd_pkg::M_SPLIT]);
    b2_lo     <= prod_t'(b1_dmag) * prod_t'(b1_mmag[shd_pkg::M_SPLIT-1:0]);
    b2_pneg   <= b1_pneg;
    b2_interp <= b1_interp;
    b2_held   <= b1_held;
    b2_older  <= b1_older;

    b3_q      <= wide_sum[WideW-1:shd_pkg::FRAC];
    b3_pneg   <= b2_pneg;
    b3_interp <= b2_interp;
    b3_held   <= b2_held;
    b3_older  <= b2_older;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb1 <= 1'b0;
      vb2 <= 1'b0;
      vb3 <= 1'b0;
    end else begin
      vb1 <= rd_en;
      vb2 <= vb1;
      vb3 <= vb2;
    end
  end

  // Result queue, show-ahead read.
  assign opop = pop && !empty;

  always_ff @(posedge clk) begin
    if (vb3) begin
      omem[owr_ptr] <= y_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= '0;
      ord_ptr <= '0;
      ocount  <= '0;
    end else begin
      if (vb3) begin
        owr_ptr <= owr_ptr + 1'b1;
      end
      if (opop) begin
        ord_ptr <= ord_ptr + 1'b1;
      end
      ocount <= ocount + shd_pkg::out_cnt_t'(vb3) - shd_pkg::out_cnt_t'(opop);
    end
  end

  assign empty      = (ocount == '0);
  assign out_sample = omem[ord_ptr];

endmodule

### sv/sample_hold_downsampler.sv
// ----------------------------------------------------------------------------
// Sample-and-hold downsampler
// Audio sample-and-hold rate reducer with phase accumulator and optional
// linear interpolation in negative frequency mode.
// ----------------------------------------------------------------------------
// Usage:
// Items enter as a queue push: sample and freq are taken at a clock edge
// where push is high and full is low. Results leave as a queue pop: while
// empty is low, out_sample shows the oldest result, which is taken at an
// edge where pop is high. Every item gives exactly one result, in order.
// One item can be accepted on every cycle while full is low. The front
// end computes the clipped step (two stages, split multiplier), a four-item
// queue decouples it from the back end, which updates the phase, held and
// older samples once per item and then runs a three-stage interpolation
// pipeline into an eight-item result queue.
// When pop stays low the result queue fills, the back end stops taking
// items from the middle queue, and full rises once that queue and the
// front stages hold four items; nothing is dropped.
// A synchronous reset empties both queues, sets phase to 1.0 and the held
// and older samples to zero, and loads the register reset values.
// Registers (64-bit port): recip_rate at byte 0, interpolate at byte 8.
// Write them only while no items are in flight.
// ----------------------------------------------------------------------------
module sample_hold_downsampler (
  input  logic                                     clk,
  input  logic                                     rst,

  // Input item channel.
  input  logic                                     push,
  output logic                                     full,
  input  logic signed [shd_pkg::SAMPLE_WIDTH-1:0]  sample,
  input  logic signed [shd_pkg::FREQ_WIDTH-1:0]    freq,

  // Result item channel.
  output logic                                     empty,
  input  logic                                     pop,
  output logic signed [shd_pkg::SAMPLE_WIDTH-1:0]  out_sample,

  // Configuration port.
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [shd_pkg::ADDR_WIDTH-1:0]           paddr,
  input  logic [shd_pkg::DATA_WIDTH-1:0]           pwdata,
  output logic [shd_pkg::DATA_WIDTH-1:0]           prdata,
  output logic                                     pready
);

  logic [shd_pkg::RECIP_WIDTH-1:0]  recip_rate;
  logic                             interpolate;
  shd_pkg::shd_reg_t                reg_sel;
  logic                             cfg_write;

  logic                             accept;
  logic                             mid_wr_en;
  shd_pkg::shd_mid_t                mid_wr_item;
  logic                             mid_rd_en;
  shd_pkg::shd_mid_t                mid_rd_item;
  shd_pkg::shd_qstat_t              mid_qstat;

  // The port never inserts wait states. Register select is the address bit
  // that separates the two 8-byte slots.
  assign pready    = 1'b1;
  assign reg_sel   = shd_pkg::shd_reg_t'(paddr[shd_pkg::REG_SEL_BIT]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      recip_rate  <= shd_pkg::RECIP_RESET;
      interpolate <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        shd_pkg::REG_RECIP_RATE:  recip_rate  <= pwdata[shd_pkg::RECIP_WIDTH-1:0];
        shd_pkg::REG_INTERPOLATE: interpolate <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      shd_pkg::REG_RECIP_RATE:
        prdata = {{(shd_pkg::DATA_WIDTH-shd_pkg::RECIP_WIDTH){1'b0}}, recip_rate};
      shd_pkg::REG_INTERPOLATE:
        prdata = {{(shd_pkg::DATA_WIDTH-1){1'b0}}, interpolate};
    endcase
  end

  assign accept = push && !full;

  // Front end: step computation.
  shd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .sample     (sample),
    .freq       (freq),
    .recip_rate (recip_rate),
    .qstat      (mid_qstat),
    .full       (full),
    .wr_en      (mid_wr_en),
    .wr_item    (mid_wr_item)
  );

  // Queue that lets front and back stall independently.
  shd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_wr_en),
    .wr_item (mid_wr_item),
    .rd_en   (mid_rd_en),
    .rd_item (mid_rd_item),
    .qstat   (mid_qstat)
  );

  // Back end: phase and hold state, interpolation and the result queue.
  shd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .interpolate (interpolate),
    .qstat       (mid_qstat),
    .rd_item     (mid_rd_item),
    .rd_en       (mid_rd_en),
    .pop         (pop),
    .empty       (empty),
    .out_sample  (out_sample)
  );

endmodule

### sv/sample_hold_downsampler_checker.sv
// ----------------------------------------------------------------------------
// Sample-and-hold downsampler port checker
// Concurrent assertions on the top level's ports, attached by bind.
// ----------------------------------------------------------------------------
`include "sample_hold_downsampler_macros.svh"

module sample_hold_downsampler_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     full,
  input logic                                     empty,
  input logic                                     pop,
  input logic signed [shd_pkg::SAMPLE_WIDTH-1:0]  out_sample,
  input logic                                     psel,
  input logic                                     penable,
  input logic                                     pwrite,
  input logic [shd_pkg::ADDR_WIDTH-1:0]           paddr,
  input logic [shd_pkg::DATA_WIDTH-1:0]           pwdata,
  input logic [shd_pkg::DATA_WIDTH-1:0]           prdata,
  input logic                                     pready
);

  logic rate_wr;
  logic rate_rd;

  assign rate_wr = psel && penable && pwrite && pready && !paddr[shd_pkg::REG_SEL_BIT];
  assign rate_rd = psel && !pwrite && !paddr[shd_pkg::REG_SEL_BIT];

  // After reset both queues are empty.
  `SHD_ASSERT_ALWAYS(a_reset_queues, rst |=> (empty && !full), "queues not empty after reset")

  // A waiting result stays put until it is taken.
  `SHD_ASSERT(a_result_hold, (!empty && !pop) |=> (!empty && $stable(out_sample)), "result changed while stalled")

  // The configuration port never waits.
  `SHD_ASSERT(a_no_wait, pready, "pready dropped")

  // A rate write is read back unchanged on the next cycle.
  `SHD_ASSERT(a_rate_readback, rate_wr |=> (!rate_rd || (prdata[39:0] == $past(pwdata[39:0]) && prdata[63:40] == 24'd0)), "recip_rate read back wrong")

endmodule

bind sample_hold_downsampler sample_hold_downsampler_checker u_checker (.*);

### test/tb_sample_hold_downsampler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sample-and-hold downsampler testbench
// Drives items through the push side, pops results at random rates and
// checks each one against a local model of the phase accumulator and the
// held, older and interpolated samples, across several register settings.
// ----------------------------------------------------------------------------
module tb_sample_hold_downsampler;

  // Run shape. The cycle limit sits far above a slow run: about 720 items,
  // each with the longest input gap and the longest pop stall, plus the
  // register accesses between settings.
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int RANDOM_PHASES   = 7;
  localparam int ITEMS_PER_PHASE = 100;

  // Fixed-point constants for the local model.
  localparam longint Q29_ONE  = longint'(1) << shd_pkg::FRAC;
  localparam longint PH_HI    = 64'sd2147483647;
  localparam longint PH_LO    = -64'sd2147483648;
  localparam longint SAMP_HI  = (longint'(1) << (shd_pkg::SAMPLE_WIDTH - 1)) - 1;
  localparam longint SAMP_LO  = -SAMP_HI - 1;

  // Field extremes used by the directed rows.
  localparam logic signed [shd_pkg::SAMPLE_WIDTH-1:0] S_MAX = 24'sh7f_ffff;
  localparam logic signed [shd_pkg::SAMPLE_WIDTH-1:0] S_MIN = 24'sh80_0000;
  localparam logic signed [shd_pkg::FREQ_WIDTH-1:0]   F_MAX = 32'sh7fff_ffff;
  localparam logic signed [shd_pkg::FREQ_WIDTH-1:0]   F_MIN = 32'sh8000_0000;
  localparam logic signed [shd_pkg::FREQ_WIDTH-1:0]   HZ_1K = 32'sd4096000;
  localparam logic [shd_pkg::DATA_WIDTH-1:0]          RECIP_TOP = 64'hff_ffff_ffff;

  // A directed row is either an item or a register write. An item row may
  // carry its result typed in; otherwise the local model supplies it.
  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                               kind;
    shd_pkg::shd_reg_t                       cfg_reg;
    logic [shd_pkg::DATA_WIDTH-1:0]          value;
    logic signed [shd_pkg::SAMPLE_WIDTH-1:0] in_sample;
    logic signed [shd_pkg::FREQ_WIDTH-1:0]   in_freq;
    logic                                    typed;
    logic signed [shd_pkg::SAMPLE_WIDTH-1:0] want;
  } dir_row_t;

  // The first six items run at zero frequency straight after reset. Phase
  // starts at 1.0, so every item triggers, the output is the sample itself,
  // and phase walks down by 1.0 per item until it pins at the negative end
  // of its range. With phase pinned there, the negative-mode rows with
  // interpolation on overshoot hard and hit both sample saturation limits.
  // Later rows cover the clipped step at full-scale frequency, the widest and
  // zero reciprocal rate, and positive mode with interpolation enabled.
  localparam int NUM_ROWS = 26;
  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, S_MAX, 32'sd0, 1'b1, S_MAX},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, S_MIN, 32'sd0, 1'b1, S_MIN},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, 24'sd1, 32'sd0, 1'b1, 24'sd1},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, -24'sd1, 32'sd0, 1'b1, -24'sd1},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, 24'sd0, 32'sd0, 1'b1, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, 24'sd12345, 32'sd0, 1'b1, 24'sd12345},
    '{ROW_CFG, shd_pkg::REG_INTERPOLATE, 64'd1, 24'sd0, 32'sd0, 1'b0, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, S_MAX, -32'sd1, 1'b0, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, S_MIN, -32'sd1, 1'b0, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, 24'sd0, -32'sd1, 1'b0, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, 24'sd4000000, F_MIN, 1'b0, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, -24'sd4000000, -HZ_1K, 1'b0, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, 24'sd123456, -HZ_1K, 1'b0, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, 24'sd7, F_MAX, 1'b0, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, 24'sd8, HZ_1K, 1'b0, 24'sd0},
    '{ROW_CFG, shd_pkg::REG_RECIP_RATE, RECIP_TOP, 24'sd0, 32'sd0, 1'b0, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, -24'sd5, 32'sd1, 1'b0, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, 24'sd5, -32'sd1, 1'b0, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, 24'sd9, F_MIN, 1'b0, 24'sd0},
    '{ROW_CFG, shd_pkg::REG_RECIP_RATE, 64'd0, 24'sd0, 32'sd0, 1'b0, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, 24'sd10, -32'sd4096, 1'b0, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, 24'sd11, 32'sd4096, 1'b0, 24'sd0},
    '{ROW_CFG, shd_pkg::REG_INTERPOLATE, 64'd0, 24'sd0, 32'sd0, 1'b0, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, 24'sd12, -HZ_1K, 1'b0, 24'sd0},
    '{ROW_ITEM, shd_pkg::REG_RECIP_RATE, 64'd0, 24'sd13, F_MAX, 1'b0, 24'sd0},
    '{ROW_CFG, shd_pkg::REG_RECIP_RATE, 64'(shd_pkg::RECIP_RESET), 24'sd0, 32'sd0,
      1'b0, 24'sd0}
  };

  // Every input starts at a known value; reset is high from time zero.
  logic                                    clk = 1'b0;
  logic                                    rst = 1'b1;
  logic                                    push = 1'b0;
  logic                                    full;
  logic signed [shd_pkg::SAMPLE_WIDTH-1:0] sample = '0;
  logic signed [shd_pkg::FREQ_WIDTH-1:0]   freq = '0;
  logic                                    empty;
  logic                                    pop = 1'b0;
  logic signed [shd_pkg::SAMPLE_WIDTH-1:0] out_sample;
  logic                                    psel = 1'b0;
  logic                                    penable = 1'b0;
  logic                                    pwrite = 1'b0;
  logic [shd_pkg::ADDR_WIDTH-1:0]          paddr = '0;
  logic [shd_pkg::DATA_WIDTH-1:0]          pwdata = '0;
  logic [shd_pkg::DATA_WIDTH-1:0]          prdata;
  logic                                    pready;

  // Local copy of the block's registers and state.
  logic [shd_pkg::RECIP_WIDTH-1:0]         recip_m;
  logic                                    interp_m;
  logic signed [shd_pkg::PHASE_WIDTH-1:0]  phase_m;
  logic signed [shd_pkg::SAMPLE_WIDTH-1:0] held_m;
  logic signed [shd_pkg::SAMPLE_WIDTH-1:0] older_m;

  // Output samples owed by the block, oldest first.
  logic signed [shd_pkg::SAMPLE_WIDTH-1:0] owed_out[$];
  logic signed [shd_pkg::SAMPLE_WIDTH-1:0] owed_head;

  int  mismatches     = 0;
  int  items_in       = 0;
  int  results_out    = 0;
  int  interp_results = 0;
  int  reg_writes     = 0;
  int  cycles         = 0;
  int  pop_stall      = 0;
  bit  idle_on        = 1'b1;
  bit  neg_run        = 1'b0;

  sample_hold_downsampler u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t run stopped after %0d cycles with %0d results owed",
               $time, cycles, owed_out.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Clamp a wide value back into the signed 32-bit phase range.
  function automatic logic signed [shd_pkg::PHASE_WIDTH-1:0] clamp_phase(input longint v);
    if (v > PH_HI) begin
      return shd_pkg::PHASE_WIDTH'(PH_HI);
    end else if (v < PH_LO) begin
      return shd_pkg::PHASE_WIDTH'(PH_LO);
    end
    return shd_pkg::PHASE_WIDTH'(v);
  endfunction

  // Advance the local state by one item and return the sample that the
  // block should emit for it. The trigger test uses the phase from before
  // the step; the +/-1.0 move comes first, then the output, then the step.
  function automatic logic signed [shd_pkg::SAMPLE_WIDTH-1:0] advance_hold(
    input logic signed [shd_pkg::SAMPLE_WIDTH-1:0] x,
    input logic signed [shd_pkg::FREQ_WIDTH-1:0]   f
  );
    logic [shd_pkg::FREQ_WIDTH-1:0] mag;
    logic [71:0]                    prod;
    longint                         step;
    longint                         ph;
    longint                         y;
    mag  = f[shd_pkg::FREQ_WIDTH-1] ? shd_pkg::FREQ_WIDTH'(-f) : shd_pkg::FREQ_WIDTH'(f);
    prod = (72'(mag) * 72'(recip_m)) >> shd_pkg::STEP_SHIFT;
    if (prod > 72'(Q29_ONE)) begin
      prod = 72'(Q29_ONE);
    end
    step = f[shd_pkg::FREQ_WIDTH-1] ? -longint'(prod) : longint'(prod);
    ph = phase_m;
    if (ph >= Q29_ONE || ph <= 0) begin
      ph = clamp_phase(f[shd_pkg::FREQ_WIDTH-1] ? ph + Q29_ONE : ph - Q29_ONE);
      older_m = held_m;
      held_m  = x;
    end
    y = held_m;
    if (f[shd_pkg::FREQ_WIDTH-1] && interp_m) begin
      // Ramp from older toward held by (1 - phase); the division truncates
      // toward zero, the sum saturates to the sample range.
      y = longint'(older_m)
          + (longint'(held_m) - longint'(older_m)) * (Q29_ONE - ph) / Q29_ONE;
      if (y > SAMP_HI) begin
        y = SAMP_HI;
      end else if (y < SAMP_LO) begin
        y = SAMP_LO;
      end
      interp_results++;
    end
    phase_m = clamp_phase(ph + step);
    return shd_pkg::SAMPLE_WIDTH'(y);
  endfunction

  // Present one item at the falling edge and hold it until the edge that
  // accepts it, then book the result it owes. A typed row books its own
  // value, but the model still advances.
  task automatic send_item(
    input logic signed [shd_pkg::SAMPLE_WIDTH-1:0] s,
    input logic signed [shd_pkg::FREQ_WIDTH-1:0]   f,
    input logic                                    typed,
    input logic signed [shd_pkg::SAMPLE_WIDTH-1:0] want
  );
    logic signed [shd_pkg::SAMPLE_WIDTH-1:0] modeled;
    @(negedge clk);
    push   <= 1'b1;
    sample <= s;
    freq   <= f;
    do @(posedge clk); while (full !== 1'b0);
    modeled = advance_hold(s, f);
    owed_out.push_back(typed ? want : modeled);
    items_in++;
  endtask

  // Now and then, leave the input side idle for a burst of random length.
  task automatic push_gap();
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 13);
      @(negedge clk);
      push <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Drop push and wait until every owed result has been popped.
  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (owed_out.size() != 0) @(posedge clk);
  endtask

  // Read a register and compare it with the local copy.
  task automatic check_reg(input shd_pkg::shd_reg_t r);
    logic [shd_pkg::DATA_WIDTH-1:0] want;
    want = (r == shd_pkg::REG_RECIP_RATE) ? shd_pkg::DATA_WIDTH'(recip_m)
                                          : shd_pkg::DATA_WIDTH'(interp_m);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= shd_pkg::ADDR_WIDTH'(r) << shd_pkg::REG_SEL_BIT;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want) begin
      mismatches++;
      $display("%0t register %s read expected %0h actual %0h",
               $time, r.name(), want, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register through a setup and an access cycle, mirror it in the
  // local copy at the writing edge, then read it back.
  task automatic write_reg(input shd_pkg::shd_reg_t r,
                           input logic [shd_pkg::DATA_WIDTH-1:0] v);
    @(negedge clk);
    push    <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= shd_pkg::ADDR_WIDTH'(r) << shd_pkg::REG_SEL_BIT;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (r == shd_pkg::REG_RECIP_RATE) begin
      recip_m = v[shd_pkg::RECIP_WIDTH-1:0];
    end else begin
      interp_m = v[0];
    end
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_reg(r);
  endtask

  // Random item. Frequencies mostly sit in the audio range and keep their
  // sign for a stretch, so that hold periods and interpolation ramps play
  // out; the rest are full-range words, tiny values, extremes and zero.
  task automatic random_item(
    output logic signed [shd_pkg::SAMPLE_WIDTH-1:0] s,
    output logic signed [shd_pkg::FREQ_WIDTH-1:0]   f
  );
    int pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 23) == 0) begin
      neg_run = !neg_run;
    end
    if (pick < 55) begin
      f = $urandom_range(20 * 4096, 22050 * 4096);
    end else if (pick < 70) begin
      f = $urandom_range(22050 * 4096, 400000 * 4096);
    end else if (pick < 82) begin
      f = $urandom;
    end else if (pick < 90) begin
      f = $urandom_range(0, 3);
    end else if (pick < 96) begin
      case ($urandom_range(0, 2))
        0:       f = F_MAX;
        1:       f = F_MIN;
        default: f = F_MIN + 1;
      endcase
    end else begin
      f = '0;
    end
    if (neg_run && (pick < 70 || (pick >= 82 && pick < 90))) begin
      f = -f;
    end
    if ($urandom_range(0, 99) < 88) begin
      s = shd_pkg::SAMPLE_WIDTH'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       s = S_MAX;
        1:       s = S_MIN;
        2:       s = '0;
        default: s = -1;
      endcase
    end
  endtask

  // Result side: pop stalls in bursts of random length while idling is on.
  always @(negedge clk) begin
    if (pop_stall > 0) begin
      pop_stall <= pop_stall - 1;
      pop       <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      pop_stall <= $urandom_range(0, 12);
      pop       <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Every popped result is compared with the oldest owed sample.
  always @(posedge clk) begin
    if (!rst && pop && empty === 1'b0) begin
      if (owed_out.size() == 0) begin
        mismatches++;
        $display("%0t out_sample expected none actual %0d", $time, out_sample);
      end else begin
        owed_head = owed_out.pop_front();
        results_out++;
        if (out_sample !== owed_head) begin
          mismatches++;
          $display("%0t out_sample expected %0d actual %0d",
                   $time, owed_head, out_sample);
        end
      end
    end
  end

  initial begin
    dir_row_t                                row;
    logic signed [shd_pkg::SAMPLE_WIDTH-1:0] rnd_sample;
    logic signed [shd_pkg::FREQ_WIDTH-1:0]   rnd_freq;
    logic [shd_pkg::DATA_WIDTH-1:0]          rate;

    recip_m  = shd_pkg::RECIP_RESET;
    interp_m = 1'b0;
    phase_m  = shd_pkg::PHASE_WIDTH'(Q29_ONE);
    held_m   = '0;
    older_m  = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Registers must come out of reset at their documented values.
    check_reg(shd_pkg::REG_RECIP_RATE);
    check_reg(shd_pkg::REG_INTERPOLATE);

    // Directed part.
    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.kind == ROW_CFG) begin
        drain_results();
        write_reg(row.cfg_reg, row.value);
      end else begin
        push_gap();
        send_item(row.in_sample, row.in_freq, row.typed, row.want);
      end
    end

    // Random part: one register setting per phase, the extremes among them.
    // The last phase runs with no idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      case (p)
        0:       rate = 64'(shd_pkg::RECIP_RESET);
        2:       rate = RECIP_TOP;
        3:       rate = '0;
        4:       rate = 64'({8'($urandom), 32'($urandom)});
        5:       rate = 64'($urandom_range(1, 64)) << 30;
        default: rate = 64'(shd_pkg::RECIP_RESET);
      endcase
      write_reg(shd_pkg::REG_RECIP_RATE, rate);
      write_reg(shd_pkg::REG_INTERPOLATE, (p == 0 || p == 4) ? 64'd0 : 64'd1);
      idle_on = (p != RANDOM_PHASES - 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        push_gap();
        random_item(rnd_sample, rnd_freq);
        send_item(rnd_sample, rnd_freq, 1'b0, '0);
      end
    end

    // Let the last results out, then keep watching for strays.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items and checked %0d results across %0d register writes.",
             items_in, results_out, reg_writes);
    $display("%0d results took the interpolation path; %0d mismatches seen.",
             interp_results, mismatches);
    if (mismatches == 0 && owed_out.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
